// ===== rtl/sem_pkg.sv =====
// Shared types, widths and codes of the Sobel edge magnitude block.
// No dependencies; compiled first.
package sem_pkg;

   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int ROW_W     = 16;
   localparam int COL_W     = 11;
   localparam int FW_W      = 12;
   localparam int FH_W      = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [15:0]       ROOT_CAP = 16'd65280;
   localparam logic [CHAN_W-1:0] MAG_MAX  = 8'd255;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [PIX_W-1:0]  pix_type;

   // one column of the 3-row neighborhood
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } col_type;

   // request to the magnitude unit
   typedef struct packed {
      logic    start;
      logic    shift;
      col_type left;
      col_type center;
      col_type right;
   } mag_req_type;

   function automatic chan_type chan_of(input pix_type p, input logic [1:0] k);
      chan_type v;
      v = p[CHAN_W*k +: CHAN_W];
      return v;
   endfunction

endpackage

// ===== rtl/sem_ifs.sv =====
// Stream interfaces of the Sobel edge magnitude block: pixel request and result.
// Depends on sem_pkg.
interface sem_req_if import sem_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type in_blue;
   chan_type in_green;
   chan_type in_red;

   modport source (output valid, in_blue, in_green, in_red, input ready);
   modport sink   (input valid, in_blue, in_green, in_red, output ready);
endinterface

interface sem_rsp_if import sem_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_col;
   chan_type         out_blue;
   chan_type         out_green;
   chan_type         out_red;
   logic             frame_end;
   logic             run_last;

   modport source (output valid, out_row, out_col, out_blue, out_green, out_red,
                   frame_end, run_last, input ready);
   modport sink   (input valid, out_row, out_col, out_blue, out_green, out_red,
                   frame_end, run_last, output ready);
endinterface

// ===== rtl/sem_magnitude.sv =====
// Three-lane Sobel gradient and rounded, capped square root of Gx^2+Gy^2.
// Root is found one bit per cycle. Depends on sem_pkg.
module sem_magnitude import sem_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  mag_req_type            req,
   output logic                   done,
   output logic [2:0][CHAN_W-1:0] mag
);

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_GRAD = 3'd1;
   localparam logic [2:0] M_SQR  = 3'd2;
   localparam logic [2:0] M_SUM  = 3'd3;
   localparam logic [2:0] M_ROOT = 3'd4;
   localparam logic [2:0] M_RND  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] bit_ff;
   logic       done_ff;

   col_type lt_ff, ct_ff, rt_ff;
   logic signed [10:0] gx_ff [3];
   logic signed [10:0] gy_ff [3];
   logic signed [10:0] gx_in [3];
   logic signed [10:0] gy_in [3];
   logic [19:0] sx_ff [3];
   logic [19:0] sy_ff [3];
   logic [19:0] sx_in [3];
   logic [19:0] sy_in [3];
   logic [15:0] s_ff [3];
   logic        cap_ff [3];
   logic [7:0]  root_ff [3];
   logic [7:0]  root_in [3];
   logic [7:0]  res_in [3];
   logic [2:0][CHAN_W-1:0] mag_ff;

   // drop the top row for the last-row window
   function automatic col_type shifted(input col_type c, input logic sh);
      col_type o;
      o = sh ? col_type'{top: c.mid, mid: c.bot, bot: '0} : c;
      return o;
   endfunction

   function automatic logic signed [10:0] ext(input chan_type v);
      logic signed [10:0] o;
      o = $signed({3'b000, v});
      return o;
   endfunction

   // gradients, squares, root step and rounding per lane
   always_comb begin
      logic signed [21:0] gxw, gyw;
      logic [7:0]  trial;
      logic [15:0] tsq;
      logic [16:0] rr;
      for (int k = 0; k < 3; k++) begin
         gx_in[k] = (ext(chan_of(rt_ff.top, 2'(k))) + (ext(chan_of(rt_ff.mid, 2'(k))) <<< 1)
                   + ext(chan_of(rt_ff.bot, 2'(k))))
                  - (ext(chan_of(lt_ff.top, 2'(k))) + (ext(chan_of(lt_ff.mid, 2'(k))) <<< 1)
                   + ext(chan_of(lt_ff.bot, 2'(k))));
         gy_in[k] = (ext(chan_of(lt_ff.bot, 2'(k))) + (ext(chan_of(ct_ff.bot, 2'(k))) <<< 1)
                   + ext(chan_of(rt_ff.bot, 2'(k))))
                  - (ext(chan_of(lt_ff.top, 2'(k))) + (ext(chan_of(ct_ff.top, 2'(k))) <<< 1)
                   + ext(chan_of(rt_ff.top, 2'(k))));
         gxw = 22'(gx_ff[k]);
         gyw = 22'(gy_ff[k]);
         sx_in[k] = 20'(gxw * gxw);
         sy_in[k] = 20'(gyw * gyw);
         trial = root_ff[k] | (8'd1 << bit_ff);
         tsq = {8'b0, trial} * {8'b0, trial};
         root_in[k] = (tsq <= s_ff[k]) ? trial : root_ff[k];
         rr = {9'b0, root_ff[k]} * {9'b0, root_ff[k]} + {9'b0, root_ff[k]};
         if (cap_ff[k]) begin
            res_in[k] = MAG_MAX;
         end else if ({1'b0, s_ff[k]} > rr) begin
            res_in[k] = root_ff[k] + 8'd1;
         end else begin
            res_in[k] = root_ff[k];
         end
      end
   end

   // sequence the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
         bit_ff   <= 3'd7;
      end else begin
         done_ff <= (state_ff == M_RND);
         case (state_ff)
            M_IDLE: if (req.start) state_ff <= M_GRAD;
            M_GRAD: state_ff <= M_SQR;
            M_SQR:  state_ff <= M_SUM;
            M_SUM: begin
               state_ff <= M_ROOT;
               bit_ff   <= 3'd7;
            end
            M_ROOT: begin
               if (bit_ff == 3'd0) state_ff <= M_RND;
               bit_ff <= bit_ff - 3'd1;
            end
            M_RND: begin
               state_ff <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      logic [20:0] sum;
      if (state_ff == M_IDLE && req.start) begin
         lt_ff <= shifted(req.left, req.shift);
         ct_ff <= shifted(req.center, req.shift);
         rt_ff <= shifted(req.right, req.shift);
      end
      for (int k = 0; k < 3; k++) begin
         if (state_ff == M_GRAD) begin
            gx_ff[k] <= gx_in[k];
            gy_ff[k] <= gy_in[k];
         end
         if (state_ff == M_SQR) begin
            sx_ff[k] <= sx_in[k];
            sy_ff[k] <= sy_in[k];
         end
         if (state_ff == M_SUM) begin
            sum = {1'b0, sx_ff[k]} + {1'b0, sy_ff[k]};
            cap_ff[k]  <= sum > {5'b0, ROOT_CAP};
            s_ff[k]    <= sum[15:0];
            root_ff[k] <= 8'd0;
         end
         if (state_ff == M_ROOT) root_ff[k] <= root_in[k];
         if (state_ff == M_RND) mag_ff[k] <= res_in[k];
      end
   end

   assign done = done_ff;
   assign mag  = mag_ff;

endmodule

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// Top level of the Sobel edge magnitude block: counters, line store, result sequencing.
// Depends on sem_pkg, sem_ifs and sem_magnitude.
//
//  channel   direction  handshake          payload
//  req_port  in         valid/ready        in_blue, in_green, in_red
//  rsp_port  out        valid/ready        row, col, three magnitudes, frame_end, run_last
//  csr_*     in         write enable only  index 0 frame_width, 1 frame_height
//
// One pixel at a time: the line store is read in the accept cycle and written back
// in ST_MEM, then each of its 0..4 results goes through the bit-per-cycle root
// loop of the magnitude unit and is emitted; the block returns to idle and takes
// the next pixel once the last result is in the output register.
// Reset is synchronous; the line store holds no reset, rows above the frame are masked.
// A stalled result holds in the output register; the next result waits for it.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   sem_req_if.sink              req_port,
   sem_rsp_if.source            rsp_port,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MEM  = 3'd1;
   localparam logic [2:0] ST_CALC = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   // result kinds in emission order
   localparam logic [1:0] RK_UP_LEFT  = 2'd0;
   localparam logic [1:0] RK_UP_HERE  = 2'd1;
   localparam logic [1:0] RK_CUR_LEFT = 2'd2;
   localparam logic [1:0] RK_CUR_HERE = 2'd3;

   logic [2:0]       state_ff;
   logic [FW_W-1:0]  fw_ff;
   logic [FH_W-1:0]  fh_ff;
   logic [ROW_W-1:0] row_cnt_ff;
   logic [COL_W-1:0] col_cnt_ff;
   logic [ROW_W-1:0] irow_ff;
   logic [COL_W-1:0] icol_ff;
   logic [3:0]       pend_ff;
   logic [AW-1:0]    idx_ff;
   pix_type          pix_ff;
   col_type          cola_ff, colb_ff, colc_ff;
   col_type          winl_ff, winr_ff;
   logic [2*PIX_W-1:0] mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rdata_ff;

   logic                   rsp_valid_ff;
   logic [ROW_W-1:0]       rsp_row_ff;
   logic [COL_W-1:0]       rsp_col_ff;
   logic [2:0][CHAN_W-1:0] rsp_mag_ff;
   logic                   rsp_fend_ff;
   logic                   rsp_last_ff;

   logic [WW-1:0]   w_eff;
   logic [FH_W-1:0] h_last;
   logic            lc, lr, accept, out_free;
   logic [1:0]      sel;
   logic [3:0]      sel_bit;
   logic            mag_done;
   logic [2:0][CHAN_W-1:0] mag;
   mag_req_type     mreq;
   pix_type         pix_in;

   assign pix_in = {req_port.in_red, req_port.in_green, req_port.in_blue};

   // effective frame size and last-column / last-row tests
   always_comb begin
      w_eff = WW'(fw_ff);
      if (w_eff == '0) w_eff = WW'(1);
      if (w_eff > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
      h_last = (fh_ff == '0) ? '0 : fh_ff - 16'd1;
      lc = WW'(col_cnt_ff) >= (w_eff - WW'(1));
      lr = row_cnt_ff >= h_last;
   end

   assign accept        = (state_ff == ST_IDLE) && req_port.valid;
   assign req_port.ready = (state_ff == ST_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_port.ready;

   // pick the first pending result
   always_comb begin
      if (pend_ff[0])      sel = RK_UP_LEFT;
      else if (pend_ff[1]) sel = RK_UP_HERE;
      else if (pend_ff[2]) sel = RK_CUR_LEFT;
      else                 sel = RK_CUR_HERE;
      sel_bit = 4'd1 << sel;
   end

   // build the window for the selected result
   always_comb begin
      mreq.start = (state_ff == ST_CALC);
      mreq.shift = (sel == RK_CUR_LEFT) || (sel == RK_CUR_HERE);
      if ((sel == RK_UP_LEFT) || (sel == RK_CUR_LEFT)) begin
         mreq.left   = cola_ff;
         mreq.center = colb_ff;
         mreq.right  = colc_ff;
      end else begin
         mreq.left   = colb_ff;
         mreq.center = colc_ff;
         mreq.right  = '0;
      end
   end

   sem_magnitude u_mag (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .done  (mag_done),
      .mag   (mag)
   );

   // line store: older row in the upper half, newer row in the lower half
   always_ff @(posedge clock) begin
      if (state_ff == ST_MEM) mem[idx_ff] <= {rdata_ff[PIX_W-1:0], pix_ff};
      if (accept) rdata_ff <= mem[AW'(col_cnt_ff)];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fw_ff        <= FW_W'(640);
         fh_ff        <= FH_W'(480);
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         pend_ff      <= '0;
         winl_ff      <= '0;
         winr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff <= csr_data[FW_W-1:0];
               CSR_FRAME_HEIGHT: fh_ff <= csr_data[FH_W-1:0];
               default: ;
            endcase
         end
         // raise valid on an emitted result, drop it once the transaction is taken
         if (state_ff == ST_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_port.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_MEM;
                  pend_ff  <= {lr && lc, lr && (col_cnt_ff != '0),
                               (row_cnt_ff != '0) && lc,
                               (row_cnt_ff != '0) && (col_cnt_ff != '0)};
                  if (lc) begin
                     col_cnt_ff <= '0;
                     row_cnt_ff <= lr ? '0 : row_cnt_ff + 16'd1;
                  end else begin
                     col_cnt_ff <= col_cnt_ff + 11'd1;
                  end
               end
            end
            ST_MEM: begin
               if (pend_ff == '0) begin
                  state_ff <= ST_IDLE;
                  winl_ff  <= colb_ff;
                  winr_ff  <= col_type'{top: (irow_ff >= 16'd2) ? rdata_ff[2*PIX_W-1:PIX_W] : '0,
                                        mid: (irow_ff != '0) ? rdata_ff[PIX_W-1:0] : '0,
                                        bot: pix_ff};
               end else begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: state_ff <= ST_WAIT;
            ST_WAIT: if (mag_done) state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (out_free) begin
                  pend_ff      <= pend_ff & ~sel_bit;
                  if ((pend_ff & ~sel_bit) == '0) begin
                     state_ff <= ST_IDLE;
                     winl_ff  <= colb_ff;
                     winr_ff  <= colc_ff;
                  end else begin
                     state_ff <= ST_CALC;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // item payload and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= pix_in;
         irow_ff <= row_cnt_ff;
         icol_ff <= col_cnt_ff;
         idx_ff  <= AW'(col_cnt_ff);
         cola_ff <= (col_cnt_ff == '0) ? '0 : winl_ff;
         colb_ff <= (col_cnt_ff == '0) ? '0 : winr_ff;
      end
      if (state_ff == ST_MEM) begin
         colc_ff <= col_type'{top: (irow_ff >= 16'd2) ? rdata_ff[2*PIX_W-1:PIX_W] : '0,
                              mid: (irow_ff != '0) ? rdata_ff[PIX_W-1:0] : '0,
                              bot: pix_ff};
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_row_ff  <= ((sel == RK_UP_LEFT) || (sel == RK_UP_HERE)) ? irow_ff - 16'd1
                                                                     : irow_ff;
         rsp_col_ff  <= ((sel == RK_UP_LEFT) || (sel == RK_CUR_LEFT)) ? icol_ff - 11'd1
                                                                      : icol_ff;
         rsp_mag_ff  <= mag;
         rsp_fend_ff <= (sel == RK_CUR_HERE);
         rsp_last_ff <= ((pend_ff & ~sel_bit) == '0);
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.out_row   = rsp_row_ff;
   assign rsp_port.out_col   = rsp_col_ff;
   assign rsp_port.out_blue  = rsp_mag_ff[0];
   assign rsp_port.out_green = rsp_mag_ff[1];
   assign rsp_port.out_red   = rsp_mag_ff[2];
   assign rsp_port.frame_end = rsp_fend_ff;
   assign rsp_port.run_last  = rsp_last_ff;

endmodule

// ===== rtl/sem_checker.sv =====
// Port-level checks of the Sobel edge magnitude block and their bind to the top level.
// Depends on sem_pkg and sobel_edge_magnitude_rgb.
module sem_checker import sem_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [ROW_W-1:0] rsp_row,
   input logic [COL_W-1:0] rsp_col,
   input logic             rsp_frame_end,
   input logic             rsp_run_last
);

   // one pixel in flight: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // the frame's last result closes its pixel's run
   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("frame_end without run_last");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row) && $stable(rsp_col)
         && $stable(rsp_frame_end) && $stable(rsp_run_last))
      else $error("stalled result changed");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_port.valid),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_row       (rsp_port.out_row),
   .rsp_col       (rsp_port.out_col),
   .rsp_frame_end (rsp_port.frame_end),
   .rsp_run_last  (rsp_port.run_last)
);

// ===== tb/tb_sobel_edge_magnitude_rgb.sv =====
// Self-checking testbench for sobel_edge_magnitude_rgb: streams RGB frames of configured
// size, predicts every edge magnitude result and checks the result stream in order.
// Depends on sem_pkg, sem_ifs and the RTL of the block.
module tb_sobel_edge_magnitude_rgb;
   import sem_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = 2048;
   localparam int NUM_PIXELS = 170;
   localparam int DIRECTED   = 16;
   localparam int SETTLE     = 150;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      chan_type         blue;
      chan_type         green;
      chan_type         red;
      logic             frame_end;
      logic             run_last;
   } edge_result_type;

   // Frame tracker and expected edge results
   class edge_scoreboard;
      pix_type         older_line[LINE_DEPTH];
      pix_type         newer_line[LINE_DEPTH];
      pix_type         win[6];
      int unsigned     row_cnt;
      int unsigned     col_cnt;
      int unsigned     width_reg;
      int unsigned     height_reg;
      edge_result_type pending_edges[$];
      int              mismatches;

      function new();
         width_reg  = 640;
         height_reg = 480;
         row_cnt    = 0;
         col_cnt    = 0;
         mismatches = 0;
         foreach (win[k]) win[k] = '0;
         foreach (older_line[k]) begin
            older_line[k] = '0;
            newer_line[k] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         if (idx == CSR_FRAME_WIDTH) width_reg = value[FW_W-1:0];
         else height_reg = value;
      endfunction

      // nearest integer root of gx^2+gy^2, capped
      function int unsigned nearest_root(int unsigned s);
         int unsigned r;
         if (s > 65280) return 255;
         r = 0;
         while ((r + 1) * (r + 1) <= s) r++;
         if (s > r * r + r) r++;
         return (r > 255) ? 255 : r;
      endfunction

      function chan_type sobel_mag(pix_type a[3], pix_type b[3], pix_type c[3],
                                   int sh, int ch);
         int p[3][3];
         int gx;
         int gy;
         pix_type cur;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               cur = (j == 0) ? a[(k + sh) % 3] : (j == 1) ? b[(k + sh) % 3] : c[(k + sh) % 3];
               p[k][j] = (k + sh < 3) ? int'(cur[8*ch +: 8]) : 0;
            end
         end
         gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
         gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
         return chan_type'(nearest_root(gx * gx + gy * gy));
      endfunction

      function void push_edge(int unsigned r, int unsigned c, pix_type a[3], pix_type b[3],
                              pix_type d[3], int sh, bit fend);
         edge_result_type e;
         e.row       = r[ROW_W-1:0];
         e.col       = c[COL_W-1:0];
         e.blue      = sobel_mag(a, b, d, sh, 0);
         e.green     = sobel_mag(a, b, d, sh, 1);
         e.red       = sobel_mag(a, b, d, sh, 2);
         e.frame_end = fend;
         e.run_last  = 1'b0;
         pending_edges.push_back(e);
      endfunction

      // Advance the raster position for one accepted pixel and queue its results
      function void note_pixel(pix_type pix);
         int unsigned w;
         int unsigned h;
         int unsigned idx;
         int          before_cnt;
         pix_type     top;
         pix_type     mid;
         pix_type     ca[3];
         pix_type     cb[3];
         pix_type     cc[3];
         pix_type     cz[3];
         bit          lc;
         bit          lr;
         w = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
         h = (height_reg == 0) ? 1 : height_reg;
         if (col_cnt == 0) foreach (win[k]) win[k] = '0;
         idx = col_cnt % LINE_DEPTH;
         top = older_line[idx];
         mid = newer_line[idx];
         older_line[idx] = mid;
         newer_line[idx] = pix;
         if (row_cnt < 2) top = '0;
         if (row_cnt < 1) mid = '0;
         lc = col_cnt >= w - 1;
         lr = row_cnt >= h - 1;
         for (int k = 0; k < 3; k++) begin
            ca[k] = win[k];
            cb[k] = win[3 + k];
            cz[k] = '0;
         end
         cc[0] = top;
         cc[1] = mid;
         cc[2] = pix;
         before_cnt = pending_edges.size();
         if (row_cnt >= 1) begin
            if (col_cnt >= 1) push_edge(row_cnt - 1, col_cnt - 1, ca, cb, cc, 0, 0);
            if (lc) push_edge(row_cnt - 1, col_cnt, cb, cc, cz, 0, 0);
         end
         if (lr) begin
            if (col_cnt >= 1) push_edge(row_cnt, col_cnt - 1, ca, cb, cc, 1, 0);
            if (lc) push_edge(row_cnt, col_cnt, cb, cc, cz, 1, 1);
         end
         if (pending_edges.size() > before_cnt)
            pending_edges[pending_edges.size() - 1].run_last = 1'b1;
         for (int k = 0; k < 3; k++) begin
            win[k]     = cb[k];
            win[3 + k] = cc[k];
         end
         if (lc) begin
            col_cnt = 0;
            row_cnt = lr ? 0 : ((row_cnt + 1) & 16'hFFFF);
         end else begin
            col_cnt = (col_cnt + 1) & 11'h7FF;
         end
      endfunction

      function void check_edge(edge_result_type got);
         edge_result_type want;
         if (pending_edges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: %p", got);
            return;
         end
         want = pending_edges.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected %p, actual %p", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data  = '0;
   int                   send_idle = 0;
   int                   recv_idle = 0;
   int                   sent      = 0;
   edge_scoreboard       sb;

   sem_req_if req_port ();
   sem_rsp_if rsp_port ();

   sobel_edge_magnitude_rgb dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port.sink),
      .rsp_port  (rsp_port.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      req_port.valid    = 1'b0;
      req_port.in_blue  = '0;
      req_port.in_green = '0;
      req_port.in_red   = '0;
      rsp_port.ready    = 1'b0;
   end

   // Stall the result channel at random and check every result transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_port.ready <= 1'b0;
      end else begin
         rsp_port.ready <= ($urandom_range(99) >= recv_idle);
         if (rsp_port.valid && rsp_port.ready)
            sb.check_edge({rsp_port.out_row, rsp_port.out_col, rsp_port.out_blue,
                           rsp_port.out_green, rsp_port.out_red, rsp_port.frame_end,
                           rsp_port.run_last});
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic set_frame(int unsigned w, int unsigned h);
      write_reg(CSR_FRAME_WIDTH, CSR_W'(w));
      write_reg(CSR_FRAME_HEIGHT, CSR_W'(h));
   endtask

   // Drop valid through idle gaps, then present one pixel until accepted
   task automatic send_pixel(chan_type b, chan_type g, chan_type r);
      while ($urandom_range(99) < send_idle) begin
         req_port.valid <= 1'b0;
         @(posedge clock);
      end
      req_port.valid    <= 1'b1;
      req_port.in_blue  <= b;
      req_port.in_green <= g;
      req_port.in_red   <= r;
      @(posedge clock);
      while (!req_port.ready) @(posedge clock);
      sb.note_pixel({r, g, b});
      sent++;
   endtask

   // Drop valid and let every expected result drain before touching registers
   task automatic drain();
      req_port.valid <= 1'b0;
      while (sb.pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_random_pixel();
      chan_type v;
      if ($urandom_range(7) == 0) begin
         v = $urandom_range(1) ? 8'hFF : 8'h00;
         send_pixel(v, v, v);
      end else begin
         send_pixel(chan_type'($urandom), chan_type'($urandom), chan_type'($urandom));
      end
   endtask

   initial begin
      int unsigned fw;
      int unsigned fh;
      int unsigned stop_at;
      int unsigned cap_w;
      sb = new();
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single-pixel frame
      set_frame(1, 1);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      drain();

      // Directed: 3x3 frame with hard edges that saturate the magnitude
      set_frame(3, 3);
      for (int i = 0; i < 9; i++)
         send_pixel((i % 2) ? 8'hFF : 8'h00, (i % 3 == 0) ? 8'hFF : 8'h00,
                    chan_type'($urandom));
      drain();

      // Directed: oversized width and full height, then shrink mid-frame to zero sizes
      set_frame(4095, 65535);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      drain();
      set_frame(0, 0);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h80, 8'h7F, 8'h01);
      drain();

      // Random frames; an occasional frame stops early and the next one is no wider
      cap_w = 8;
      while (sent < NUM_PIXELS) begin
         case ((sent - DIRECTED) * 3 / (NUM_PIXELS - DIRECTED))
            0: begin send_idle = 35; recv_idle = 68; end
            1: begin send_idle = 68; recv_idle = 35; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         fw = $urandom_range(1, cap_w);
         fh = $urandom_range(1, 6);
         set_frame(fw, fh);
         stop_at = ($urandom_range(5) == 0) ? $urandom_range(1, fw * fh) : fw * fh;
         if (stop_at > NUM_PIXELS - sent) stop_at = NUM_PIXELS - sent;
         cap_w = (stop_at < fw * fh) ? fw : 8;
         for (int unsigned i = 0; i < stop_at; i++) send_random_pixel();
         drain();
      end

      if (sb.mismatches == 0 && sb.pending_edges.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
